// ===== design/tpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// shared types, sizes and helpers of the temporal pair prefetcher
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int IP_SLOTS    = 16;
  localparam int ENTRY_SLOTS = 8;
  localparam int MAX_DEGREE  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int PAGE_SHIFT  = 12;

  localparam int PAIRS   = IP_SLOTS * ENTRY_SLOTS;
  localparam int SLOT_W  = (IP_SLOTS > 1) ? $clog2(IP_SLOTS) : 1;
  localparam int ENT_W   = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int PADDR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int DEG_CAP = (MAX_DEGREE < MAX_RESULTS) ? MAX_DEGREE : MAX_RESULTS;

  localparam int CMD_W  = 2;
  localparam int IP_W   = 48;
  localparam int LINE_W = 58;
  localparam int PAGE_W = 52;
  localparam int CONF_W = 4;
  localparam int DEG_W  = 4;
  localparam int AGE_W  = 8;
  localparam int CFG_W  = 4;

  localparam int IN_TDATA_W  = ((CMD_W + IP_W + LINE_W + PAGE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LINE_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRAIN   = 2'd0,
    CMD_PREDICT = 2'd1,
    CMD_ERASE   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  localparam logic REG_CONF_MAX = 1'b0;
  localparam logic REG_DEGREE   = 1'b1;

  typedef enum logic {
    CMP_TAG   = 1'b0,
    CMP_START = 1'b1
  } cmp_sel_e;

  typedef struct packed {
    cmp_sel_e          sel;
    logic [IP_W-1:0]   tag;
    logic [IP_W-1:0]   ip;
    logic [LINE_W-1:0] cur;
    logic [LINE_W-1:0] start;
  } cmp_req_t;

  typedef struct packed {
    logic [LINE_W-1:0] start;
    logic [LINE_W-1:0] nxt;
    logic [CONF_W-1:0] conf;
    logic [AGE_W-1:0]  age;
  } pair_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    return (a == {AGE_W{1'b1}}) ? a : a + 1'b1;
  endfunction

  function automatic logic [PAGE_W-1:0] line_page(input logic [LINE_W-1:0] l);
    logic [LINE_W-1:0] s;
    s = l >> PAGE_SHIFT;
    return s[PAGE_W-1:0];
  endfunction

  function automatic logic [DEG_W-1:0] deg_lim(input logic [DEG_W-1:0] d);
    return (int'(d) > DEG_CAP) ? DEG_W'(DEG_CAP) : d;
  endfunction

endpackage

// ===== design/temporal_pair_prefetcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_pair_prefetcher
// per instruction address temporal pair prefetcher with a scanning sequencer
// ----------------------------------------------------------------------------
// sequence: the ip search scans every ip slot in turn, then a dispatch step
// train with a pair update adds a search pass and an update pass over the entries
// predict adds a search pass over the entries per chain step plus an output step per result word
// throughput: one command at a time, ready only when idle; the single shared
// compare unit and the pair memory, read and written at one address, serialise the work
// reset: ip and pair valid bits clear at once, conf_max 3, degree 4
// ----------------------------------------------------------------------------
module temporal_pair_prefetcher
  import tpp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // command words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cmd, ip, line_addr, page_num (lowest bit up)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // result words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // prefetch_addr, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // addr_valid, status
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_IP_SCAN  = 10'b0000000010,
    S_DISPATCH = 10'b0000000100,
    S_P1_RD    = 10'b0000001000,
    S_P1_CK    = 10'b0000010000,
    S_PDEC     = 10'b0000100000,
    S_P2_RD    = 10'b0001000000,
    S_P2_WR    = 10'b0010000000,
    S_PCONT    = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // latched command word
  cmd_e              cmd_q;
  logic [IP_W-1:0]   ip_q;
  logic [LINE_W-1:0] line_q;
  logic [PAGE_W-1:0] page_q;

  // ip table, tags and last lines need no reset since valid guards them
  logic [IP_W-1:0]   ip_tag_q    [IP_SLOTS];
  logic [LINE_W-1:0] last_line_q [IP_SLOTS];
  logic [IP_SLOTS-1:0] ip_valid_q;
  logic [PAIRS-1:0]    pair_valid_q;

  // scan bookkeeping
  logic [SLOT_W-1:0] i_q, i_d;
  logic [ENT_W-1:0]  e_q, e_d;
  logic              hit_q, hit_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              free_q, free_d;
  logic [SLOT_W-1:0] free_slot_q, free_slot_d;
  logic              ph_q, ph_d;
  logic [ENT_W-1:0]  ph_idx_q, ph_idx_d;
  pair_t             ph_word_q, ph_word_d;
  logic              pf_q, pf_d;
  logic [ENT_W-1:0]  pf_idx_q, pf_idx_d;
  logic [ENT_W-1:0]  vic_idx_q, vic_idx_d;
  logic [AGE_W-1:0]  vic_age_q, vic_age_d;

  // chain following
  logic [LINE_W-1:0] cur_q, cur_d;
  logic [LINE_W-1:0] pend_q, pend_d;
  logic              pendv_q, pendv_d;
  logic [DEG_W-1:0]  n_q, n_d;
  logic              done_q, done_d;

  // output register
  logic [LINE_W-1:0] out_addr_q, out_addr_d;
  logic              out_av_q, out_av_d;
  logic              out_last_q, out_last_d;
  logic              out_st_q, out_st_d;

  // config registers
  logic [CONF_W-1:0] conf_max_q;
  logic [DEG_W-1:0]  degree_q;

  // table update strobes
  logic       alloc, erase, ll_wr, pset;
  logic       ram_we;
  pair_t      ram_wdata;
  pair_t      rdata;
  logic       eq;
  cmp_req_t   cmp_req;
  logic       s_accept;
  logic [DEG_W-1:0]   lim;
  logic [PADDR_W-1:0] pbase, paddr;
  logic               pv;
  logic [ENT_W-1:0]   victim;
  logic               same_nxt, conf_zero;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign lim      = deg_lim(degree_q);
  assign pbase    = PADDR_W'(int'(slot_q) * ENTRY_SLOTS);
  assign paddr    = pbase + PADDR_W'(e_q);
  assign pv       = pair_valid_q[paddr];
  assign victim   = pf_q ? pf_idx_q : vic_idx_q;
  assign same_nxt = (ph_word_q.nxt == line_q);
  assign conf_zero = (ph_word_q.conf == '0);

  // one compare unit serves both searches
  always_comb begin
    cmp_req.sel   = (state_q == S_IP_SCAN) ? CMP_TAG : CMP_START;
    cmp_req.tag   = ip_tag_q[i_q];
    cmp_req.ip    = ip_q;
    cmp_req.cur   = cur_q;
    cmp_req.start = rdata.start;
  end

  tpp_match_unit u_match (
    .req_i (cmp_req),
    .eq_o  (eq)
  );

  tpp_pair_ram u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (paddr),
    .wdata_i (ram_wdata),
    .raddr_i (paddr),
    .rdata_o (rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {{(OUT_TDATA_W-LINE_W){1'b0}}, out_addr_q};
  assign m_axis_tuser  = {out_st_q, out_av_q};
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    e_d         = e_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    free_d      = free_q;
    free_slot_d = free_slot_q;
    ph_d        = ph_q;
    ph_idx_d    = ph_idx_q;
    ph_word_d   = ph_word_q;
    pf_d        = pf_q;
    pf_idx_d    = pf_idx_q;
    vic_idx_d   = vic_idx_q;
    vic_age_d   = vic_age_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    pendv_d     = pendv_q;
    n_d         = n_q;
    done_d      = done_q;
    out_addr_d  = out_addr_q;
    out_av_d    = out_av_q;
    out_last_d  = out_last_q;
    out_st_d    = out_st_q;
    alloc       = 1'b0;
    erase       = 1'b0;
    ll_wr       = 1'b0;
    pset        = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = rdata;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          i_d     = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = S_IP_SCAN;
        end
      end

      // one ip slot per cycle, first hit and first free slot kept
      S_IP_SCAN: begin
        if (ip_valid_q[i_q] && eq && !hit_q) begin
          hit_d  = 1'b1;
          slot_d = i_q;
        end
        if (!ip_valid_q[i_q] && !free_q) begin
          free_d      = 1'b1;
          free_slot_d = i_q;
        end
        if (i_q == SLOT_W'(IP_SLOTS - 1)) begin
          state_d = S_DISPATCH;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      S_DISPATCH: begin
        // default: single empty result
        out_addr_d = '0;
        out_av_d   = 1'b0;
        out_last_d = 1'b1;
        out_st_d   = 1'b0;
        done_d     = 1'b1;
        state_d    = S_OUT;
        case (cmd_q)
          CMD_TRAIN: begin
            if (!hit_q) begin
              if (free_q) begin
                alloc = 1'b1;
              end else begin
                out_st_d = 1'b1;
              end
            end else if (line_page(last_line_q[slot_q]) == page_q) begin
              ll_wr = 1'b1;
            end else begin
              cur_d   = last_line_q[slot_q];
              e_d     = '0;
              ph_d    = 1'b0;
              pf_d    = 1'b0;
              state_d = S_P1_RD;
            end
          end
          CMD_PREDICT: begin
            if (hit_q && lim != '0) begin
              cur_d   = line_q;
              pendv_d = 1'b0;
              n_d     = '0;
              e_d     = '0;
              ph_d    = 1'b0;
              pf_d    = 1'b0;
              state_d = S_P1_RD;
            end
          end
          CMD_ERASE: begin
            erase = hit_q;
          end
          default: begin
          end
        endcase
      end

      S_P1_RD: begin
        state_d = S_P1_CK;
      end

      // search pass: first matching pair, first free pair, oldest pair
      S_P1_CK: begin
        if (pv && eq && !ph_q) begin
          ph_d      = 1'b1;
          ph_idx_d  = e_q;
          ph_word_d = rdata;
        end
        if (!pv && !pf_q) begin
          pf_d     = 1'b1;
          pf_idx_d = e_q;
        end
        if (e_q == '0 || rdata.age > vic_age_q) begin
          vic_idx_d = e_q;
          vic_age_d = rdata.age;
        end
        if (e_q == ENT_W'(ENTRY_SLOTS - 1)) begin
          e_d     = '0;
          state_d = (cmd_q == CMD_TRAIN) ? S_P2_RD : S_PDEC;
        end else begin
          e_d     = e_q + 1'b1;
          state_d = S_P1_RD;
        end
      end

      // one chain step decided; the held address goes out once its
      // successor step is known, so last can be set on it
      S_PDEC: begin
        if (!ph_q) begin
          out_addr_d = pendv_q ? pend_q : '0;
          out_av_d   = pendv_q;
          out_last_d = 1'b1;
          out_st_d   = 1'b0;
          done_d     = 1'b1;
          state_d    = S_OUT;
        end else begin
          pend_d  = ph_word_q.nxt;
          pendv_d = 1'b1;
          cur_d   = ph_word_q.nxt;
          n_d     = n_q + 1'b1;
          if (pendv_q) begin
            out_addr_d = pend_q;
            out_av_d   = 1'b1;
            out_last_d = 1'b0;
            out_st_d   = 1'b0;
            done_d     = 1'b0;
            state_d    = S_OUT;
          end else begin
            state_d = S_PCONT;
          end
        end
      end

      S_PCONT: begin
        if (n_q == lim) begin
          out_addr_d = pend_q;
          out_av_d   = 1'b1;
          out_last_d = 1'b1;
          out_st_d   = 1'b0;
          done_d     = 1'b1;
          state_d    = S_OUT;
        end else begin
          e_d     = '0;
          ph_d    = 1'b0;
          pf_d    = 1'b0;
          state_d = S_P1_RD;
        end
      end

      S_P2_RD: begin
        state_d = S_P2_WR;
      end

      // update pass: rewrite the hit or victim pair, age other valid pairs, on a hit only if same_nxt or conf_zero
      S_P2_WR: begin
        if (ph_q) begin
          if (e_q == ph_idx_q) begin
            ram_we        = 1'b1;
            ram_wdata.age = '0;
            if (same_nxt) begin
              if (rdata.conf < conf_max_q) begin
                ram_wdata.conf = rdata.conf + 1'b1;
              end
            end else if (conf_zero) begin
              ram_wdata.nxt  = line_q;
              ram_wdata.conf = conf_max_q;
            end else begin
              ram_wdata.conf = rdata.conf - 1'b1;
            end
          end else if (pv && (same_nxt || conf_zero)) begin
            ram_we        = 1'b1;
            ram_wdata.age = age_inc(rdata.age);
          end
        end else begin
          if (e_q == victim) begin
            ram_we          = 1'b1;
            pset            = 1'b1;
            ram_wdata.start = cur_q;
            ram_wdata.nxt   = line_q;
            ram_wdata.conf  = conf_max_q;
            ram_wdata.age   = '0;
          end else if (pv) begin
            ram_we        = 1'b1;
            ram_wdata.age = age_inc(rdata.age);
          end
        end
        if (e_q == ENT_W'(ENTRY_SLOTS - 1)) begin
          ll_wr      = 1'b1;
          out_addr_d = '0;
          out_av_d   = 1'b0;
          out_last_d = 1'b1;
          out_st_d   = 1'b0;
          done_d     = 1'b1;
          state_d    = S_OUT;
        end else begin
          e_d     = e_q + 1'b1;
          state_d = S_P2_RD;
        end
      end

      S_OUT: begin
        if (m_axis_tready) begin
          state_d = done_q ? S_IDLE : S_PCONT;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      conf_max_q <= CONF_W'(3);
      degree_q   <= DEG_W'(4);
      ip_valid_q <= '0;
      pair_valid_q <= '0;
      i_q     <= '0;
      e_q     <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      ph_q    <= 1'b0;
      pf_q    <= 1'b0;
      pendv_q <= 1'b0;
      n_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      e_q     <= e_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      ph_q    <= ph_d;
      pf_q    <= pf_d;
      pendv_q <= pendv_d;
      n_q     <= n_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CONF_MAX: conf_max_q <= cfg_data_i;
          REG_DEGREE:   degree_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (alloc) begin
        ip_valid_q[free_slot_q] <= 1'b1;
        for (int k = 0; k < ENTRY_SLOTS; k++) begin
          pair_valid_q[PADDR_W'(int'(free_slot_q) * ENTRY_SLOTS + k)] <= 1'b0;
        end
      end
      if (erase) begin
        ip_valid_q[slot_q] <= 1'b0;
        for (int k = 0; k < ENTRY_SLOTS; k++) begin
          pair_valid_q[PADDR_W'(int'(slot_q) * ENTRY_SLOTS + k)] <= 1'b0;
        end
      end
      if (pset) begin
        pair_valid_q[paddr] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= cmd_e'(s_axis_tdata[CMD_W-1:0]);
      ip_q   <= s_axis_tdata[CMD_W +: IP_W];
      line_q <= s_axis_tdata[CMD_W+IP_W +: LINE_W];
      page_q <= s_axis_tdata[CMD_W+IP_W+LINE_W +: PAGE_W];
    end
    if (alloc) begin
      ip_tag_q[free_slot_q]    <= ip_q;
      last_line_q[free_slot_q] <= line_q;
    end
    if (ll_wr) begin
      last_line_q[slot_q] <= line_q;
    end
    slot_q      <= slot_d;
    free_slot_q <= free_slot_d;
    ph_idx_q    <= ph_idx_d;
    ph_word_q   <= ph_word_d;
    pf_idx_q    <= pf_idx_d;
    vic_idx_q   <= vic_idx_d;
    vic_age_q   <= vic_age_d;
    cur_q       <= cur_d;
    pend_q      <= pend_d;
    out_addr_q  <= out_addr_d;
    out_av_q    <= out_av_d;
    out_last_q  <= out_last_d;
    out_st_q    <= out_st_d;
  end

endmodule

// ===== design/tpp_match_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_match_unit
// shared equality compare for the ip tag search and the pair start search
// ----------------------------------------------------------------------------
module tpp_match_unit
  import tpp_pkg::*;
(
  input  cmp_req_t req_i,
  output logic     eq_o
);

  logic [LINE_W-1:0] a;
  logic [LINE_W-1:0] b;

  always_comb begin
    case (req_i.sel)
      CMP_TAG: begin
        a = {{(LINE_W-IP_W){1'b0}}, req_i.tag};
        b = {{(LINE_W-IP_W){1'b0}}, req_i.ip};
      end
      CMP_START: begin
        a = req_i.cur;
        b = req_i.start;
      end
      default: begin
        a = '0;
        b = '1;
      end
    endcase
  end

  assign eq_o = (a == b);

endmodule

// ===== design/tpp_pair_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pair_ram
// pair store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tpp_pair_ram
  import tpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [PADDR_W-1:0] waddr_i,
  input  pair_t              wdata_i,
  input  logic [PADDR_W-1:0] raddr_i,
  output pair_t              rdata_o
);

  pair_t mem_q [PAIRS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== tb/temporal_pair_prefetcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_pair_prefetcher_test
// self-checking bench: a behavioral table model predicts every result word,
// bursty command driver and stalling result monitor, several config settings
// ----------------------------------------------------------------------------
module temporal_pair_prefetcher_test;
  import tpp_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // cmd, ip, line_addr, page_num (lowest bit up)
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // prefetch_addr, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // addr_valid, status
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  temporal_pair_prefetcher dut (.*);

  // packed from the top down, so cmd lands in the lowest bits
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [LINE_W-1:0] line;
    logic [IP_W-1:0]   ip;
    cmd_e              cmd;
  } access_t;

  typedef struct packed {
    logic [LINE_W-1:0] addr;
    logic              vld;
    logic              lst;
    logic              st;
  } pf_word_t;

  // behavioral copy of the prefetcher table
  logic [IP_W-1:0]   m_tag   [IP_SLOTS];
  logic              m_ipv   [IP_SLOTS];
  logic              m_seen  [IP_SLOTS];
  logic [LINE_W-1:0] m_last  [IP_SLOTS];
  logic              m_pv    [PAIRS];
  logic [LINE_W-1:0] m_start [PAIRS];
  logic [LINE_W-1:0] m_next  [PAIRS];
  logic [CONF_W-1:0] m_conf  [PAIRS];
  logic [AGE_W-1:0]  m_age   [PAIRS];
  logic [CONF_W-1:0] m_conf_max;
  logic [DEG_W-1:0]  m_degree;

  access_t  pending_q[$];
  pf_word_t expected_q[$];
  int errors = 0;
  int words_seen = 0;
  int prefetches_seen = 0;
  longint cycles = 0;
  bit hold_sender = 0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic void drop_slot(int s);
    m_ipv[s] = 0; m_tag[s] = '0; m_seen[s] = 0; m_last[s] = '0;
    for (int e = 0; e < ENTRY_SLOTS; e++) begin
      m_pv[s*ENTRY_SLOTS+e] = 0; m_start[s*ENTRY_SLOTS+e] = '0;
      m_next[s*ENTRY_SLOTS+e] = '0; m_conf[s*ENTRY_SLOTS+e] = '0;
      m_age[s*ENTRY_SLOTS+e] = '0;
    end
  endfunction

  function automatic int find_ip(logic [IP_W-1:0] ip);
    for (int s = 0; s < IP_SLOTS; s++) if (m_ipv[s] && m_tag[s] == ip) return s;
    return -1;
  endfunction

  function automatic int find_start(int s, logic [LINE_W-1:0] st);
    for (int e = 0; e < ENTRY_SLOTS; e++)
      if (m_pv[s*ENTRY_SLOTS+e] && m_start[s*ENTRY_SLOTS+e] == st) return s*ENTRY_SLOTS+e;
    return -1;
  endfunction

  function automatic void age_rest(int s, int keep);
    for (int e = 0; e < ENTRY_SLOTS; e++) begin
      int p;
      p = s*ENTRY_SLOTS + e;
      if (m_pv[p] && p != keep && m_age[p] != 8'hff) m_age[p]++;
    end
  endfunction

  function automatic void learn_pair(int s, logic [LINE_W-1:0] st, logic [LINE_W-1:0] nx);
    int p;
    int v;
    p = find_start(s, st);
    if (p >= 0) begin
      if (m_next[p] == nx) begin
        if (m_conf[p] < m_conf_max) m_conf[p]++;
        age_rest(s, p);
      end else if (m_conf[p] == 0) begin
        m_next[p] = nx; m_conf[p] = m_conf_max; age_rest(s, p);
      end else begin
        m_conf[p]--;
      end
      m_age[p] = '0;
      return;
    end
    age_rest(s, -1);
    v = -1;
    for (int e = 0; e < ENTRY_SLOTS; e++)
      if (v < 0 && !m_pv[s*ENTRY_SLOTS+e]) v = s*ENTRY_SLOTS+e;
    if (v < 0) begin
      v = s*ENTRY_SLOTS;
      for (int e = 1; e < ENTRY_SLOTS; e++)
        if (m_age[s*ENTRY_SLOTS+e] > m_age[v]) v = s*ENTRY_SLOTS+e;
    end
    m_pv[v] = 1; m_start[v] = st; m_next[v] = nx; m_conf[v] = m_conf_max; m_age[v] = '0;
  endfunction

  // apply one command to the table and queue the words it must produce
  function automatic void predict_words(access_t a);
    int s;
    int n;
    int lim;
    int f;
    int p;
    logic st;
    logic [LINE_W-1:0] cur;
    pf_word_t w;
    s = find_ip(a.ip);
    st = 0;
    n = 0;
    case (a.cmd)
      CMD_TRAIN: begin
        if (s < 0) begin
          f = -1;
          for (int i = 0; i < IP_SLOTS; i++) if (f < 0 && !m_ipv[i]) f = i;
          if (f < 0) st = 1;
          else begin
            drop_slot(f);
            m_ipv[f] = 1; m_tag[f] = a.ip; m_last[f] = a.line; m_seen[f] = 1;
          end
        end else begin
          if (m_seen[s] && (m_last[s] >> PAGE_SHIFT) != LINE_W'(a.page))
            learn_pair(s, m_last[s], a.line);
          m_last[s] = a.line; m_seen[s] = 1;
        end
      end
      CMD_PREDICT: begin
        lim = (m_degree > DEG_CAP) ? DEG_CAP : m_degree;
        if (s >= 0) begin
          cur = a.line;
          while (n < lim) begin
            p = find_start(s, cur);
            if (p < 0) break;
            cur = m_next[p];
            w = '{addr: cur, vld: 1'b1, lst: 1'b0, st: 1'b0};
            expected_q.insert(expected_q.size(), w);
            n++;
          end
          if (n > 0) expected_q[$].lst = 1'b1;
        end
      end
      CMD_ERASE: if (s >= 0) drop_slot(s);
      default: ;
    endcase
    if (n == 0) begin
      w = '{addr: '0, vld: 1'b0, lst: 1'b1, st: st};
      expected_q.insert(expected_q.size(), w);
    end
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: bursts of words with random gaps, model updated on acceptance
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_words(s_axis_tdata[CMD_W+IP_W+LINE_W+PAGE_W-1:0]);
      void'(pending_q.pop_front());
    end
    if (s_axis_tvalid && !s_axis_tready) begin
      // word waits, hold it steady
    end else if (rst_ni && !hold_sender && pending_q.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'(pending_q[0]);
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor: stalls on its own pattern, checks each word against the model
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) m_axis_tready <= (cycles % 64 < 16) ? 1'b1 : ($urandom_range(0, 2) != 0);
    if (m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (m_axis_tuser[0]) prefetches_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word addr=%h valid=%b last=%b status=%b", $time,
                 m_axis_tdata[LINE_W-1:0], m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
        errors++;
      end else begin
        pf_word_t e;
        e = expected_q.pop_front();
        if (m_axis_tdata[LINE_W-1:0] !== e.addr || m_axis_tuser[0] !== e.vld ||
            m_axis_tlast !== e.lst || m_axis_tuser[1] !== e.st ||
            m_axis_tdata[OUT_TDATA_W-1:LINE_W] !== '0) begin
          $display("%0t: mismatch expected addr=%h valid=%b last=%b status=%b", $time,
                   e.addr, e.vld, e.lst, e.st);
          $display("%0t:          actual   addr=%h valid=%b last=%b status=%b", $time,
                   m_axis_tdata[LINE_W-1:0], m_axis_tuser[0], m_axis_tlast,
                   m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > 2_000_000) begin
      $display("temporal_pair_prefetcher_test: done, errors");
      $finish;
    end
  end

  function automatic logic [LINE_W-1:0] rand_line();
    return LINE_W'({$urandom(), $urandom()});
  endfunction

  function automatic void push(cmd_e c, logic [IP_W-1:0] ip, logic [LINE_W-1:0] l,
                               logic [PAGE_W-1:0] pg);
    access_t a;
    a = '{cmd: c, ip: ip, line: l, page: pg};
    pending_q.insert(pending_q.size(), a);
  endfunction

  // pick the line's own page now and then, a random page otherwise
  function automatic logic [PAGE_W-1:0] page_of(logic [LINE_W-1:0] l);
    return ($urandom_range(0, 3) == 0) ? PAGE_W'(l >> PAGE_SHIFT) : PAGE_W'({$urandom(), $urandom()});
  endfunction

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CONF_MAX) m_conf_max = val; else m_degree = val;
  endtask

  // random phase: a few hot ips walking short line chains, plus noise
  task automatic random_phase(int count);
    logic [IP_W-1:0] ips[6];
    logic [LINE_W-1:0] lines[5];
    int k;
    for (int i = 0; i < 6; i++) ips[i] = IP_W'({$urandom(), $urandom()});
    for (int i = 0; i < 5; i++) lines[i] = rand_line();
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        logic [LINE_W-1:0] l;
        l = lines[$urandom_range(0, 4)];
        push(CMD_TRAIN, ips[$urandom_range(0, 5)], l, page_of(l) ^ PAGE_W'(1));
      end else if (k < 85)
        push(CMD_PREDICT, ips[$urandom_range(0, 5)], lines[$urandom_range(0, 4)], '0);
      else if (k < 90) push(CMD_ERASE, ips[$urandom_range(0, 5)], '0, '0);
      else if (k < 93) push(CMD_NONE, ips[0], rand_line(), '0);
      else push(cmd_e'($urandom_range(0, 2)), IP_W'({$urandom(), $urandom()}), rand_line(),
                PAGE_W'({$urandom(), $urandom()}));
    end
  endtask

  initial begin
    rst_ni = 0;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
    for (int s = 0; s < IP_SLOTS; s++) drop_slot(s);
    m_conf_max = 3; m_degree = 4;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extremes, chain follow, full ip table, erase
    push(CMD_PREDICT, '1, '1, '1);
    push(CMD_TRAIN, '1, '1, '1);
    push(CMD_TRAIN, '1, '0, '1);
    push(CMD_TRAIN, '1, 58'h1234, '0);
    push(CMD_TRAIN, '1, 58'h5555, 52'h1);
    push(CMD_PREDICT, '1, '1, '0);
    push(CMD_PREDICT, '1, '0, '0);
    push(CMD_TRAIN, '1, 58'h2aa_aaaa_aaaa_aaaa, '1);
    push(CMD_NONE, '0, '1, '1);
    push(CMD_ERASE, 48'h1, '0, '0);
    for (int i = 1; i < IP_SLOTS + 1; i++) push(CMD_TRAIN, IP_W'(i), LINE_W'(i), '0);
    push(CMD_ERASE, '1, '0, '0);
    push(CMD_PREDICT, '1, '1, '0);
    drain();
    for (int i = 1; i < IP_SLOTS + 1; i++) push(CMD_ERASE, IP_W'(i), '0, '0);

    random_phase(30);
    drain();
    write_reg(REG_CONF_MAX, 4'd15);
    write_reg(REG_DEGREE, 4'd8);
    random_phase(30);
    // pause until every word is back, then resume
    wait (pending_q.size() <= 15);
    hold_sender = 1;
    wait (expected_q.size() == 0);
    hold_sender = 0;
    drain();
    write_reg(REG_CONF_MAX, 4'd1);
    write_reg(REG_DEGREE, 4'd1);
    random_phase(30);
    drain();
    write_reg(REG_DEGREE, 4'd15);
    write_reg(REG_CONF_MAX, 4'd0);
    random_phase(30);
    drain();

    $display("covered %0d result words, %0d of them prefetch addresses, under four settings",
             words_seen, prefetches_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("temporal_pair_prefetcher_test: done, clean");
    end else begin
      $display("temporal_pair_prefetcher_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== temporal_pair_prefetcher.f =====
design/tpp_pkg.sv
design/tpp_match_unit.sv
design/tpp_pair_ram.sv
design/temporal_pair_prefetcher.sv
tb/temporal_pair_prefetcher_test.sv
